// File: design/sliding_window_median_filter_assert.svh
// Assertion macros for the sliding window median filter checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swmf_pkg.sv
// Package for the sliding window median filter: payload structs and field widths.
// No dependencies; imported by the top level and its checker.
package swmf_pkg;

    localparam int ANGLE_W = 16;
    localparam int RANGE_W = 16;
    localparam int WIDTH_W = 4;

    localparam logic [WIDTH_W-1:0] WINDOW_WIDTH_RESET = 4'd5;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] point_angle;
        logic [RANGE_W-1:0]        point_range;
        logic                      scan_last;
    } point_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] out_angle;
        logic [RANGE_W-1:0]        out_range;
        logic                      out_last;
    } point_out_t;

endpackage

// File: design/sliding_window_median_filter.sv
// Sliding window median filter over a stream of scan points.
// Depends on swmf_pkg for the payload structs and field widths.
//
// Usage: scan points enter on the point channel (point_valid/point_ready) and
// filtered points leave on the result channel (result_valid/result_ready).
// The window width is written through the cfg channel, which is always ready;
// write it only while the block is idle between requests.
// Each point is emitted once sup = width/2 later points have arrived. Its range
// becomes the lower median of the width ranges centered on it, or stays raw
// when that window runs past either end of the scan. On a request marked
// scan_last, every still delayed point is flushed in scan order.
// Sequence: the block takes one request at a time. It accepts the request, plans, and
// passes every emitted point through store read, latch and output. A median point also
// tries up to w candidates in turn on the single shared range comparator, loading each
// candidate and then streaming the window past it.
// Reset empties the scan, sets the width to 5 and drops any pending result; the
// window store needs no clearing, since only entries of the current scan are read.
// When the receiver stalls, the result waits in the output register and the
// sequencer stops at its next emission until that register is taken.
module sliding_window_median_filter
    import swmf_pkg::*;
#(
    parameter int MAX_WIDTH = 15
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_ready,
    input  point_in_t          point,
    output logic               result_valid,
    input  logic               result_ready,
    output point_out_t         result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data
);

    localparam int SLOT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PS_W   = $clog2(MAX_WIDTH + 1);
    localparam int SUM_W  = $clog2(2 * MAX_WIDTH);

    // One store entry holds a point's angle and range.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0]        range;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_EMIT_RD,
        S_EMIT_LATCH,
        S_MED_CAND,
        S_MED_SCAN,
        S_EMIT_OUT
    } state_t;

    // Store slot of the point received "back" requests before the newest one.
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] newest,
                                                    input logic [3:0] back);
        logic [SUM_W-1:0] n_ext;
        logic [SUM_W-1:0] b_ext;
        logic [SUM_W-1:0] base;
        n_ext = SUM_W'(newest);
        b_ext = SUM_W'(back);
        base  = (n_ext >= b_ext) ? n_ext : n_ext + SUM_W'(MAX_WIDTH);
        return SLOT_W'(base - b_ext);
    endfunction

    state_t                state_reg;
    logic [WIDTH_W-1:0]    window_width_reg;
    logic [SLOT_W-1:0]     write_slot_reg;
    logic [SLOT_W-1:0]     write_slot_next;
    logic [PS_W-1:0]       points_seen_reg;
    logic [PS_W-1:0]       points_seen_next;
    logic [SLOT_W-1:0]     newest_reg;
    logic [PS_W-1:0]       ps_item_reg;
    logic                  last_reg;
    logic [3:0]            w_reg;
    logic [2:0]            sup_reg;
    logic [2:0]            k_reg;
    logic                  med_ok_reg;
    logic [2:0]            d_reg;
    logic [3:0]            i_reg;
    logic [3:0]            j_reg;
    logic                  b_pend_reg;
    logic [3:0]            below_reg;
    logic [3:0]            upto_reg;
    logic signed [ANGLE_W-1:0] angle_hold_reg;
    logic [RANGE_W-1:0]    range_hold_reg;
    point_out_t            result_reg;
    logic                  result_valid_reg;

    entry_t                mem [MAX_WIDTH];
    entry_t                wr_entry;
    entry_t                a_q_reg;
    entry_t                b_q_reg;
    logic [SLOT_W-1:0]     a_addr;
    logic [SLOT_W-1:0]     b_addr;

    logic [3:0]            w_eff;
    logic                  cmp_lt;
    logic                  cmp_eq;
    logic                  accept;
    logic                  out_load;

    assign point_ready  = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign accept       = point_valid && point_ready;

    // The output register takes a new point when it is empty or being taken.
    assign out_load = (state_reg == S_EMIT_OUT) && (!result_valid_reg || result_ready);

    // A width above the store size acts as the store size.
    assign w_eff = (32'(window_width_reg) > MAX_WIDTH) ? 4'(MAX_WIDTH) : window_width_reg;

    assign write_slot_next  = (write_slot_reg == SLOT_W'(MAX_WIDTH - 1))
                            ? '0 : write_slot_reg + SLOT_W'(1);
    assign points_seen_next = (points_seen_reg == PS_W'(MAX_WIDTH))
                            ? points_seen_reg : points_seen_reg + PS_W'(1);

    // Port A reads the point being emitted, then the median candidate.
    // Port B walks the window for the rank count.
    assign a_addr = slot_back(newest_reg, (state_reg == S_EMIT_RD) ? {1'b0, d_reg} : i_reg);
    assign b_addr = slot_back(newest_reg, j_reg);

    assign wr_entry.angle = point.point_angle;
    assign wr_entry.range = point.point_range;

    // The shared compare unit: window entry against the current candidate.
    assign cmp_lt = (b_q_reg.range < a_q_reg.range);
    assign cmp_eq = (b_q_reg.range == a_q_reg.range);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[write_slot_reg] <= wr_entry;
        end
        a_q_reg <= mem[a_addr];
        b_q_reg <= mem[b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg <= WINDOW_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_width_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            write_slot_reg   <= '0;
            points_seen_reg  <= '0;
            newest_reg       <= '0;
            ps_item_reg      <= '0;
            last_reg         <= 1'b0;
            w_reg            <= '0;
            sup_reg          <= '0;
            k_reg            <= '0;
            med_ok_reg       <= 1'b0;
            d_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            b_pend_reg       <= 1'b0;
            below_reg        <= '0;
            upto_reg         <= '0;
            angle_hold_reg   <= '0;
            range_hold_reg   <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (point_valid)
                    begin
                        // The scan restarts after its last point.
                        newest_reg      <= write_slot_reg;
                        write_slot_reg  <= point.scan_last ? '0 : write_slot_next;
                        points_seen_reg <= point.scan_last ? '0 : points_seen_next;
                        ps_item_reg     <= points_seen_next;
                        last_reg        <= point.scan_last;
                        w_reg           <= w_eff;
                        sup_reg         <= w_eff[3:1];
                        k_reg           <= 3'((w_eff - 4'd1) >> 1);
                        state_reg       <= S_PLAN;
                    end
                end

                S_PLAN:
                begin
                    med_ok_reg <= (w_reg != 4'd0) && (ps_item_reg >= PS_W'(w_reg));
                    if (last_reg)
                    begin
                        // Flush from the oldest delayed point down to the newest.
                        d_reg     <= (ps_item_reg > PS_W'(sup_reg)) ? sup_reg
                                                                    : 3'(ps_item_reg - PS_W'(1));
                        state_reg <= S_EMIT_RD;
                    end
                    else if (ps_item_reg > PS_W'(sup_reg))
                    begin
                        d_reg     <= sup_reg;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LATCH;
                end

                S_EMIT_LATCH:
                begin
                    angle_hold_reg <= a_q_reg.angle;
                    range_hold_reg <= a_q_reg.range;
                    i_reg          <= '0;
                    // Only the point at the full delay has a complete window.
                    state_reg      <= (med_ok_reg && (d_reg == sup_reg)) ? S_MED_CAND : S_EMIT_OUT;
                end

                S_MED_CAND:
                begin
                    j_reg      <= '0;
                    b_pend_reg <= 1'b0;
                    below_reg  <= '0;
                    upto_reg   <= '0;
                    state_reg  <= S_MED_SCAN;
                end

                S_MED_SCAN:
                begin
                    if (j_reg != w_reg)
                    begin
                        j_reg      <= j_reg + 4'd1;
                        b_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        b_pend_reg <= 1'b0;
                    end

                    if (b_pend_reg)
                    begin
                        below_reg <= below_reg + {3'b000, cmp_lt};
                        upto_reg  <= upto_reg + {3'b000, cmp_lt | cmp_eq};
                    end

                    if ((j_reg == w_reg) && !b_pend_reg)
                    begin
                        // The candidate whose rank range covers k is the lower median.
                        if (((below_reg <= {1'b0, k_reg}) && ({1'b0, k_reg} < upto_reg))
                            || (i_reg == w_reg - 4'd1))
                        begin
                            range_hold_reg <= a_q_reg.range;
                            state_reg      <= S_EMIT_OUT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 4'd1;
                            state_reg <= S_MED_CAND;
                        end
                    end
                end

                S_EMIT_OUT:
                begin
                    if (out_load)
                    begin
                        result_reg.out_angle <= angle_hold_reg;
                        result_reg.out_range <= range_hold_reg;
                        result_reg.out_last  <= last_reg && (d_reg == 3'd0);
                        if (!last_reg || (d_reg == 3'd0))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            d_reg     <= d_reg - 3'd1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/swmf_checker.sv
// Port-level checker for the sliding window median filter, with its bind.
// Depends on swmf_pkg and the macros in sliding_window_median_filter_assert.svh.
`include "sliding_window_median_filter_assert.svh"

module swmf_checker
    import swmf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               point_valid,
    input logic               point_ready,
    input point_in_t          point,
    input logic               result_valid,
    input logic               result_ready,
    input point_out_t         result
);

    // A stalled result must hold still until it is taken.
    `SWMF_ASSERT_NEXT(a_result_hold,
        result_valid && !result_ready,
        result_valid && $stable(result),
        "result changed or dropped while stalled")

    // A waiting request must hold still until it is taken.
    `SWMF_ASSERT_NEXT(a_point_hold,
        point_valid && !point_ready,
        point_valid && $stable(point),
        "point request changed or dropped while waiting")

    // The block works on one request at a time, so it is busy right after taking one.
    `SWMF_ASSERT_NEXT(a_busy_after_accept,
        point_valid && point_ready,
        !point_ready,
        "point channel ready right after an accepted request")

    // A new result only appears while a request is being worked on.
    `SWMF_ASSERT_SAME(a_result_from_busy,
        $rose(result_valid),
        $past(!point_ready),
        "result appeared while the block was idle")

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (.*);

// File: bench/median_point_checker.sv
`timescale 1ns / 100ps
// Result checker for the sliding window median filter: watches the point, result and width
// channels, predicts the filtered points and compares them. Depends on swmf_pkg.
module median_point_checker
    import swmf_pkg::*;
#(
    parameter int MAX_WIDTH = 15
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_ready,
    input  point_in_t          point,
    input  logic               result_valid,
    input  logic               result_ready,
    input  point_out_t         result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data,
    output int                 mismatch_count,
    output int                 pending_points
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    logic [RANGE_W-1:0]        range_ring [MAX_WIDTH];
    logic signed [ANGLE_W-1:0] angle_ring [MAX_WIDTH];
    logic [CNT_W-1:0]          slot;
    logic [CNT_W-1:0]          seen;
    logic [WIDTH_W-1:0]        width_reg;
    point_out_t                expected_points [$];
    int                        mismatches;

    // Ring position of the point received d requests before the newest one.
    function automatic int ring_back(int d);
        return (int'(slot) + 2 * MAX_WIDTH - 1 - d) % MAX_WIDTH;
    endfunction

    // Lower median (sorted position (w-1)/2) of the w newest ranges.
    function automatic logic [RANGE_W-1:0] lower_median(int w);
        logic [RANGE_W-1:0] vals [MAX_WIDTH];
        logic [RANGE_W-1:0] v;
        int i;
        int j;
        for (i = 0; i < w; i++)
            vals[i] = range_ring[ring_back(i)];
        for (i = 1; i < w; i++)
        begin
            v = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > v)
            begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = v;
        end
        return vals[(w - 1) / 2];
    endfunction

    task automatic queue_point(int d, bit use_median, bit last, int w);
        point_out_t r;
        int s;
        s = ring_back(d);
        r.out_angle = angle_ring[s];
        r.out_range = use_median ? lower_median(w) : range_ring[s];
        r.out_last  = last;
        expected_points.push_back(r);
    endtask

    task automatic predict_filtered_points(point_in_t p);
        int w;
        int sup;
        int pend;
        int delay;
        w = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        range_ring[slot] = p.point_range;
        angle_ring[slot] = p.point_angle;
        slot = CNT_W'((int'(slot) + 1) % MAX_WIDTH);
        if (int'(seen) < MAX_WIDTH)
            seen = seen + 1'b1;
        sup = (w <= 1) ? 0 : (w - 1) - (w - 1) / 2;
        if (!p.scan_last)
        begin
            if (int'(seen) > sup)
                queue_point(sup, w >= 1 && int'(seen) >= w, 1'b0, w);
        end
        else
        begin
            // Flush everything still delayed, oldest first.
            pend = (int'(seen) < sup + 1) ? int'(seen) : sup + 1;
            for (delay = pend - 1; delay >= 0; delay--)
                queue_point(delay, delay == sup && w >= 1 && int'(seen) >= w, delay == 0, w);
            slot = '0;
            seen = '0;
        end
    endtask

    task automatic check_point(point_out_t got);
        point_out_t want;
        if (expected_points.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected point: angle %0d range %0d last %0b",
                         got.out_angle, got.out_range, got.out_last);
            mismatches++;
        end
        else
        begin
            want = expected_points.pop_front();
            if (got.out_angle !== want.out_angle || got.out_range !== want.out_range ||
                got.out_last !== want.out_last)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected angle %0d range %0d last %0b got %0d %0d %0b",
                             want.out_angle, want.out_range, want.out_last,
                             got.out_angle, got.out_range, got.out_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_points.delete();
            slot       = '0;
            seen       = '0;
            width_reg  = WINDOW_WIDTH_RESET;
            mismatches = 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_point(result);
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            if (point_valid && point_ready)
                predict_filtered_points(point);
        end
        mismatch_count <= mismatches;
        pending_points <= expected_points.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench top for the sliding window median filter: drives scans and width writes,
// stalls the result side at random and gives the verdict. Depends on swmf_pkg and
// median_point_checker.
module tb;
    import swmf_pkg::*;

    localparam int MAX_WIDTH    = 15;
    // A median point at the largest width finishes well within this, so it covers the slowest one.
    localparam int DRAIN_CYCLES = 400;
    // Slowest correct run: every request flushing eight points, each waiting out a long
    // stall and the worst median search, several times over.
    localparam int LIMIT        = 4_000_000;
    localparam int POINT_TARGET = 365;

    logic               clk;
    logic               rst_n;
    logic               point_valid;
    logic               point_ready;
    point_in_t          point;
    logic               result_valid;
    logic               result_ready;
    point_out_t         result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WIDTH_W-1:0] cfg_data;

    int                 mismatch_count;
    int                 pending_points;
    int                 cycle_count = 0;
    int                 points_sent;
    int                 stall_left;
    logic               quiet_sender;
    logic               quiet_receiver;

    sliding_window_median_filter #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    median_point_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_valid),
        .point_ready    (point_ready),
        .point          (point),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_points (pending_points)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side. The receiver stalls now and then, mostly briefly and sometimes for
    // a long stretch; in quiet stretches it takes every result at once.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!quiet_receiver && $urandom_range(0, 99) < 25)
        begin
            result_ready <= 1'b0;
            stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 3);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Gap after a request on the point side: mostly none or short, a few long.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one point request and holds it until the block takes it. Valid stays
    // high straight into the next request when no gap follows.
    task automatic send_point(logic signed [ANGLE_W-1:0] angle, logic [RANGE_W-1:0] range,
                              logic last);
        int gap;
        point_valid <= 1'b1;
        point       <= '{point_angle: angle, point_range: range, scan_last: last};
        do
            @(posedge clk);
        while (!point_ready);
        points_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Brings the block to rest: every predicted point has come out, and then enough
    // cycles pass for a request that yields no point to finish its work as well.
    task automatic settle();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending_points != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the window width; only called while the block is at rest.
    task automatic write_width(logic [WIDTH_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int  w;
        int  eff;
        int  len;
        int  nscans;
        int  pick;
        bit  tie_heavy;
        bit  leave_open;
        logic [RANGE_W-1:0] rng;

        rst_n          = 1'b0;
        point_valid    = 1'b0;
        point          = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        points_sent    = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First a full scan at the reset width of five, with the field
        // extremes and tied ranges in the middle of the window.
        send_point(-16'sd32768, 16'hFFFF, 1'b0);
        send_point(16'sd32767, 16'h0000, 1'b0);
        send_point(16'sd0, 16'h8000, 1'b0);
        send_point(-16'sd1, 16'hFFFF, 1'b0);
        send_point(16'sd1, 16'h0001, 1'b0);
        send_point(16'sh5A5A, 16'h0000, 1'b0);
        send_point(-16'sh5A5B, 16'hFFFF, 1'b1);

        // A scan shorter than the window keeps every raw range and flushes at the end.
        send_point(16'sh1234, 16'h7FFF, 1'b0);
        send_point(-16'sh1234, 16'h0000, 1'b0);
        send_point(16'sh4000, 16'hFFFF, 1'b1);

        // Widths of zero and one pass points straight through.
        settle();
        write_width(4'd0);
        send_point(16'sh0F0F, 16'hF0F0, 1'b0);
        send_point(-16'sh0F0F, 16'h0F0F, 1'b1);
        settle();
        write_width(4'd1);
        send_point(-16'sd32768, 16'hAAAA, 1'b1);

        // Width changed in the middle of a scan: four, then two, same scan.
        settle();
        write_width(4'd4);
        send_point(16'sd100, 16'h3000, 1'b0);
        send_point(16'sd200, 16'h1000, 1'b0);
        send_point(16'sd300, 16'h2000, 1'b0);
        settle();
        write_width(4'd2);
        send_point(16'sd400, 16'h0500, 1'b0);
        send_point(16'sd500, 16'h0400, 1'b0);
        send_point(16'sd600, 16'h0600, 1'b1);

        // Largest width with a scan far too short for it.
        settle();
        write_width(4'd15);
        send_point(16'sd7, 16'hFFFE, 1'b0);
        send_point(16'sd8, 16'h0002, 1'b0);
        send_point(16'sd9, 16'h8001, 1'b1);

        // Random part: phases of one width each, a few scans per phase. Most scans are
        // long enough to reach the median, some are short, and now and then a phase
        // stops inside a scan so that the next width applies mid-scan.
        while (points_sent < POINT_TARGET)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       w = 0;
                1:       w = 1;
                2, 3:    w = 15;
                default: w = $urandom_range(2, 14);
            endcase
            eff = (w < 1) ? 1 : w;
            settle();
            write_width(WIDTH_W'(w));
            quiet_sender   <= ($urandom_range(0, 3) == 0);
            quiet_receiver <= ($urandom_range(0, 3) == 0);
            nscans     = $urandom_range(1, 3);
            leave_open = ($urandom_range(0, 5) == 0);
            for (int s = 0; s < nscans; s++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    len = $urandom_range(1, eff);
                else if (pick < 8)
                    len = $urandom_range(eff, eff + 10);
                else
                    len = $urandom_range(eff + 10, eff + 25);
                // Some scans draw ranges from four values only, to force ties.
                tie_heavy = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len; i++)
                begin
                    rng = tie_heavy ? RANGE_W'($urandom_range(0, 3) * 16'h5555)
                                    : RANGE_W'($urandom_range(0, 65535));
                    send_point(ANGLE_W'($urandom_range(0, 65535)), rng,
                               (i == len - 1) && !(leave_open && s == nscans - 1));
                end
            end
        end

        // Wait for every predicted point, then long enough to catch any stray one.
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending_points != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_points == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
